@@ rtl/core/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// LFU cache package
// Shared constants, types and the sequencer state encoding.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned LfuDepth     = 16;
  localparam int unsigned LfuCountBits = 16;
  localparam int unsigned KeyBits      = 32;
  localparam int unsigned ValBits      = 32;
  localparam int unsigned CapBits      = 5;
  localparam logic [CapBits-1:0] CapReset = 5'd16;

  localparam logic KindGet = 1'b0;
  localparam logic KindPut = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_WRITE,
    ST_DONE
  } lfu_state_e;

  typedef struct packed {
    logic                 kind;
    logic [KeyBits-1:0]   key;
    logic [ValBits-1:0]   value;
  } lfu_req_t;

  typedef struct packed {
    logic                 hit;
    logic [ValBits-1:0]   read_value;
    logic                 evicted;
    logic [KeyBits-1:0]   evicted_key;
  } lfu_rsp_t;

endpackage

@@ rtl/core/lfu_req_if.sv @@
// ----------------------------------------------------------------------------
// LFU request channel
// Valid/ready channel carrying one get or put beat.
// ----------------------------------------------------------------------------
interface lfu_req_if
  import lfu_pkg::*;
();
  logic     valid;
  logic     ready;
  lfu_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/lfu_rsp_if.sv @@
// ----------------------------------------------------------------------------
// LFU response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface lfu_rsp_if
  import lfu_pkg::*;
();
  logic     valid;
  logic     ready;
  lfu_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/lfu_ram.sv @@
// ----------------------------------------------------------------------------
// LFU generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr_i,
  output logic [Width-1:0]                              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/core/lfu_ctrl.sv @@
// ----------------------------------------------------------------------------
// LFU sequencer
// Scans the entry memory once for match, occupancy and victim, then writes
// back the touched or inserted entry. Ranks and valid bits live in flops.
// ----------------------------------------------------------------------------
module lfu_ctrl
  import lfu_pkg::*;
#(
  parameter int unsigned Depth     = LfuDepth,
  parameter int unsigned CountBits = LfuCountBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [CapBits-1:0] cfg_wdata_i,
  lfu_req_if.sink       req,
  lfu_rsp_if.source     rsp
);
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RankBits = AddrBits;
  localparam int unsigned UsedBits = $clog2(Depth + 1);
  localparam int unsigned EntBits  = KeyBits + ValBits + CountBits;
  localparam logic [AddrBits-1:0] LastIdx = AddrBits'(Depth - 1);
  localparam logic [CountBits-1:0] CountMax = '1;

  typedef struct packed {
    logic [KeyBits-1:0]   key;
    logic [ValBits-1:0]   value;
    logic [CountBits-1:0] count;
  } entry_t;

  lfu_state_e state_q, state_d;
  logic [CapBits-1:0]  cap_q;
  lfu_req_t            req_q;
  lfu_rsp_t            res_q;       // result staged until the output slot frees
  lfu_rsp_t            rsp_q;
  logic                rsp_valid_q;
  logic [Depth-1:0]    valid_q;
  logic [RankBits-1:0] rank_q [Depth];

  logic [AddrBits-1:0] raddr_q;     // address presented this cycle
  logic [AddrBits-1:0] chk_q;       // address whose data is on rdata
  logic                chk_vld_q;
  logic                hit_q;
  logic [AddrBits-1:0] hit_idx_q;
  entry_t              hit_ent_q;
  logic                vic_vld_q;
  logic [AddrBits-1:0] vic_idx_q;
  entry_t              vic_ent_q;
  logic                free_vld_q;
  logic [AddrBits-1:0] free_idx_q;
  logic [UsedBits-1:0] used_q;
  logic                last_q;

  // write-back decision
  logic                wr_q;
  logic [AddrBits-1:0] wr_idx_q;
  entry_t              wr_ent_q;
  logic                do_ins_q;
  logic                do_touch_q;
  logic                do_evict_q;
  logic [AddrBits-1:0] ev_idx_q;

  entry_t              rd_ent;
  logic [EntBits-1:0]  rdata;
  logic                ram_we;

  assign rd_ent = entry_t'(rdata);
  assign ram_we = (state_q == ST_WRITE) && wr_q;

  lfu_ram #(.Width(EntBits), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (wr_ent_q),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  logic [CapBits-1:0] limit;
  assign limit = (32'(cap_q) > Depth) ? CapBits'(Depth) : cap_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (req.valid) state_d = ST_SCAN;
      ST_SCAN:   if (last_q && chk_vld_q) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_WRITE;
      ST_WRITE:  state_d = ST_DONE;
      ST_DONE:   if (!rsp_valid_q || rsp.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready   = (state_q == ST_IDLE);
    rsp.valid   = rsp_valid_q;
    rsp.payload = rsp_q;
  end

  logic vic_better;
  always_comb begin
    vic_better = !vic_vld_q || (rd_ent.count < vic_ent_q.count) ||
                 ((rd_ent.count == vic_ent_q.count) &&
                  (rank_q[chk_q] > rank_q[vic_idx_q]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CapReset;
      rsp_valid_q <= 1'b0;
      valid_q     <= '0;
      for (int i = 0; i < Depth; i++) rank_q[i] <= '0;
      raddr_q     <= '0;
      chk_q       <= '0;
      chk_vld_q   <= 1'b0;
      last_q      <= 1'b0;
      wr_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      // load the output slot when it is free or drains this cycle
      if ((state_q == ST_DONE) && (!rsp_valid_q || rsp.ready)) begin
        rsp_valid_q <= 1'b1;
        rsp_q       <= res_q;
      end else if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req.valid) begin
            req_q      <= req.payload;
            raddr_q    <= '0;
            chk_vld_q  <= 1'b0;
            last_q     <= 1'b0;
            hit_q      <= 1'b0;
            vic_vld_q  <= 1'b0;
            free_vld_q <= 1'b0;
            used_q     <= '0;
          end
        end
        ST_SCAN: begin
          // read pipeline: address is presented the cycle before its compare
          chk_q     <= raddr_q;
          chk_vld_q <= !last_q || !chk_vld_q;
          last_q    <= (raddr_q == LastIdx);
          if (raddr_q != LastIdx) raddr_q <= raddr_q + 1'b1;
          if (chk_vld_q) begin
            if (valid_q[chk_q]) begin
              used_q <= used_q + 1'b1;
              if (!hit_q && rd_ent.key == req_q.key) begin
                hit_q     <= 1'b1;
                hit_idx_q <= chk_q;
                hit_ent_q <= rd_ent;
              end
              if (vic_better) begin
                vic_vld_q <= 1'b1;
                vic_idx_q <= chk_q;
                vic_ent_q <= rd_ent;
              end
            end else if (!free_vld_q) begin
              free_vld_q <= 1'b1;
              free_idx_q <= chk_q;
            end
          end
        end
        ST_DECIDE: begin
          do_ins_q   <= 1'b0;
          do_touch_q <= 1'b0;
          do_evict_q <= 1'b0;
          wr_q       <= 1'b0;
          res_q.hit         <= hit_q;
          res_q.read_value  <= '1;
          res_q.evicted     <= 1'b0;
          res_q.evicted_key <= '0;
          if (req_q.kind == KindGet) begin
            if (hit_q) begin
              res_q.read_value <= hit_ent_q.value;
              do_touch_q <= 1'b1;
              wr_q       <= 1'b1;
              wr_idx_q   <= hit_idx_q;
              wr_ent_q   <= '{key: hit_ent_q.key, value: hit_ent_q.value,
                              count: (hit_ent_q.count == CountMax) ? CountMax
                                     : hit_ent_q.count + 1'b1};
            end
          end else if (limit != '0) begin
            if (hit_q) begin
              do_touch_q <= 1'b1;
              wr_q       <= 1'b1;
              wr_idx_q   <= hit_idx_q;
              wr_ent_q   <= '{key: hit_ent_q.key, value: req_q.value,
                              count: (hit_ent_q.count == CountMax) ? CountMax
                                     : hit_ent_q.count + 1'b1};
            end else begin
              wr_ent_q <= '{key: req_q.key, value: req_q.value,
                            count: CountBits'(1)};
              if ((32'(used_q) >= 32'(limit)) || !free_vld_q) begin
                if (vic_vld_q) begin
                  do_evict_q <= 1'b1;
                  do_ins_q   <= 1'b1;
                  wr_q       <= 1'b1;
                  ev_idx_q   <= vic_idx_q;
                  wr_idx_q   <= vic_idx_q;
                  res_q.evicted     <= 1'b1;
                  res_q.evicted_key <= vic_ent_q.key;
                end
              end else begin
                do_ins_q <= 1'b1;
                wr_q     <= 1'b1;
                wr_idx_q <= free_idx_q;
              end
            end
          end
        end
        ST_UPDATE: begin
          // rank bookkeeping for touch, evict and insert
          for (int i = 0; i < Depth; i++) begin
            if (do_touch_q) begin
              if (AddrBits'(i) == wr_idx_q) rank_q[i] <= '0;
              else if (valid_q[i] && rank_q[i] < rank_q[wr_idx_q])
                rank_q[i] <= rank_q[i] + 1'b1;
            end else if (do_ins_q) begin
              if (AddrBits'(i) == wr_idx_q) rank_q[i] <= '0;
              else if (valid_q[i]) begin
                if (do_evict_q && rank_q[i] > rank_q[ev_idx_q])
                  rank_q[i] <= rank_q[i];
                else
                  rank_q[i] <= rank_q[i] + 1'b1;
              end
            end
          end
          if (do_ins_q) valid_q[wr_idx_q] <= 1'b1;
        end
        ST_WRITE: begin
          wr_q <= 1'b0;
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while busy");
  a_rsp_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
    else $error("response raised outside done");
  a_evict_on_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.payload.evicted) |-> !rsp.payload.hit)
    else $error("eviction reported on a hit");
`endif
endmodule

@@ rtl/core/lfu_cache_lookup_insert.sv @@
// ----------------------------------------------------------------------------
// LFU cache lookup/insert
// Fully associative key/value cache, least-frequently-used replacement with
// oldest-touch tiebreak.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   kind, key, value
//   rsp      out  valid/ready   hit, read_value, evicted, evicted_key
//   cfg      in   we            capacity_in_use
//
// Each item runs a scan that reads one entry a cycle from the entry memory,
// then decide, rank update, write-back and result.
// Reset clears all valid bits and ranks at once; no clearing pass.
// A held result blocks the next item only in its done state.
// ----------------------------------------------------------------------------
module lfu_cache_lookup_insert
  import lfu_pkg::*;
#(
  parameter int unsigned Depth     = LfuDepth,
  parameter int unsigned CountBits = LfuCountBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CapBits-1:0] cfg_wdata_i,
  lfu_req_if.sink            req,
  lfu_rsp_if.source          rsp
);
  lfu_ctrl #(.Depth(Depth), .CountBits(CountBits)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req),
    .rsp         (rsp)
  );
endmodule
